[rtl/dex_ucs_link_master_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the DEX/UCS link master
// Clocked, reset-gated concurrent assertion wrappers.
// ---------------------------------------------------------------------------
`ifndef DEX_UCS_LINK_MASTER_TOP_ASSERT_SVH
`define DEX_UCS_LINK_MASTER_TOP_ASSERT_SVH

// Generic form with an explicit clock.
`define DLM_ASSERT_AT(label, clk, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_ni) prop) \
    else $error("dlm assertion failed");

// Form for modules clocked by clk_i.
`define DLM_ASSERT(label, prop) `DLM_ASSERT_AT(label, clk_i, prop)

`endif

[rtl/dlm_pkg.sv]
// ---------------------------------------------------------------------------
// dlm_pkg
// Shared types, control characters and helpers of the DEX/UCS link master.
// ---------------------------------------------------------------------------
`default_nettype none

package dlm_pkg;

  localparam logic [7:0] CharSoh  = 8'h01;
  localparam logic [7:0] CharStx  = 8'h02;
  localparam logic [7:0] CharEtx  = 8'h03;
  localparam logic [7:0] CharEot  = 8'h04;
  localparam logic [7:0] CharEnq  = 8'h05;
  localparam logic [7:0] CharDle  = 8'h10;
  localparam logic [7:0] CharEtb  = 8'h17;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharOne  = 8'h31;

  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [4:0] SkipResponse = 5'd18;
  localparam logic [4:0] SkipCrc      = 5'd2;

  // Positions inside the ID burst
  localparam logic [4:0] IdDle1     = 5'd0;
  localparam logic [4:0] IdSoh      = 5'd1;
  localparam logic [4:0] IdTextLo   = 5'd2;
  localparam logic [4:0] IdTextHi   = 5'd18;
  localparam logic [4:0] IdDle2     = 5'd19;
  localparam logic [4:0] IdEtx      = 5'd20;
  localparam logic [4:0] IdCrcLo    = 5'd21;
  localparam logic [4:0] IdCrcHi    = 5'd22;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_COMPLETE   = 2'd0,
    ST_UNEXPECTED = 2'd1,
    ST_TIMEOUT    = 2'd2
  } status_e;

  // Burst shapes handed from front to back
  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,  // one result, fields as given
    CMD_ACK    = 2'd1,  // DLE then data
    CMD_ID     = 2'd2   // DLE SOH id-text DLE ETX crc-lo crc-hi
  } cmd_e;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_H1_DLE     = 5'd1,
    PH_H1_ZERO    = 5'd2,
    PH_H1_ACK_DLE = 5'd3,
    PH_H1_ACK_ONE = 5'd4,
    PH_H2_ENQ     = 5'd5,
    PH_H2_DLE     = 5'd6,
    PH_H2_SOH     = 5'd7,
    PH_H2_SKIP    = 5'd8,
    PH_H2_ETX_DLE = 5'd9,
    PH_H2_ETX     = 5'd10,
    PH_H2_CRC     = 5'd11,
    PH_H2_EOT     = 5'd12,
    PH_D_ENQ      = 5'd13,
    PH_D_STX_DLE  = 5'd14,
    PH_D_STX      = 5'd15,
    PH_D_DATA     = 5'd16,
    PH_D_CRC_ETB  = 5'd17,
    PH_D_CRC_ETX  = 5'd18,
    PH_D_EOT      = 5'd19
  } phase_e;

  typedef struct packed {
    cmd_e       cmd;
    kind_e      kind;
    logic [7:0] data;
    status_e    status;
  } burst_t;

  typedef struct packed {
    logic   valid;
    burst_t burst;
  } push_t;

  // Communication ID, request and revision text, by position
  function automatic logic [7:0] id_char(logic [4:0] pos);
    logic [7:0] c;
    case (pos)
      5'd0:    c = "1";
      5'd1:    c = "2";
      5'd2:    c = "3";
      5'd3:    c = "4";
      5'd4:    c = "5";
      5'd5:    c = "6";
      5'd6:    c = "7";
      5'd7:    c = "8";
      5'd8:    c = "9";
      5'd9:    c = "0";
      5'd10:   c = "R";
      5'd11:   c = "R";
      5'd12:   c = "0";
      5'd13:   c = "0";
      5'd14:   c = "L";
      5'd15:   c = "0";
      5'd16:   c = "6";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Reflected CRC-16, one byte
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  d;
    logic        mix;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ d[0];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CrcPoly;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/dlm_front.sv]
// ---------------------------------------------------------------------------
// dlm_front
// Session state machine: takes one event per cycle unless stalled and queues the burst.
// ---------------------------------------------------------------------------
`default_nettype none

module dlm_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [1:0]      op_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            queue_full_i,
  output dlm_pkg::push_t       push_o
);

  dlm_pkg::phase_e phase_q, phase_d;
  logic [4:0]      count_q, count_d;
  logic            toggle_q, toggle_d;
  logic            escape_q, escape_d;

  logic            accept;
  logic            active;
  logic            is_byte;
  logic            expecting;
  logic [7:0]      want;
  logic            bad;
  logic [4:0]      count_inc;
  logic            skip_done;
  logic            crc_done;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign active     = (phase_q != dlm_pkg::PH_IDLE);
  assign is_byte    = accept && active && (op_i == dlm_pkg::OP_BYTE);
  assign count_inc  = count_q + 5'd1;
  assign skip_done  = (count_inc >= dlm_pkg::SkipResponse);
  assign crc_done   = (count_inc >= dlm_pkg::SkipCrc);

  // Phases that wait for one fixed byte
  always_comb begin
    expecting = 1'b1;
    want      = dlm_pkg::CharDle;
    unique case (phase_q)
      dlm_pkg::PH_H1_DLE,
      dlm_pkg::PH_H1_ACK_DLE,
      dlm_pkg::PH_H2_DLE,
      dlm_pkg::PH_H2_ETX_DLE,
      dlm_pkg::PH_D_STX_DLE: want = dlm_pkg::CharDle;
      dlm_pkg::PH_H1_ZERO:    want = dlm_pkg::CharZero;
      dlm_pkg::PH_H1_ACK_ONE: want = dlm_pkg::CharOne;
      dlm_pkg::PH_H2_ENQ,
      dlm_pkg::PH_D_ENQ:      want = dlm_pkg::CharEnq;
      dlm_pkg::PH_H2_SOH:     want = dlm_pkg::CharSoh;
      dlm_pkg::PH_H2_ETX:     want = dlm_pkg::CharEtx;
      dlm_pkg::PH_H2_EOT:     want = dlm_pkg::CharEot;
      dlm_pkg::PH_D_STX:      want = dlm_pkg::CharStx;
      default:                expecting = 1'b0;
    endcase
  end

  assign bad = expecting && (rx_byte_i != want);

  // Next state
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    toggle_d = toggle_q;
    escape_d = escape_q;
    if (accept && op_i == dlm_pkg::OP_START) begin
      phase_d  = dlm_pkg::PH_H1_DLE;
      count_d  = '0;
      toggle_d = 1'b0;
      escape_d = 1'b0;
    end else if (accept && active && op_i == dlm_pkg::OP_TIMEOUT) begin
      phase_d  = dlm_pkg::PH_IDLE;
      count_d  = '0;
      toggle_d = 1'b0;
      escape_d = 1'b0;
    end else if (is_byte) begin
      unique case (phase_q)
        dlm_pkg::PH_H1_DLE:     phase_d = dlm_pkg::PH_H1_ZERO;
        dlm_pkg::PH_H1_ZERO:    phase_d = dlm_pkg::PH_H1_ACK_DLE;
        dlm_pkg::PH_H1_ACK_DLE: phase_d = dlm_pkg::PH_H1_ACK_ONE;
        dlm_pkg::PH_H1_ACK_ONE: phase_d = dlm_pkg::PH_H2_ENQ;
        dlm_pkg::PH_H2_ENQ:     phase_d = dlm_pkg::PH_H2_DLE;
        dlm_pkg::PH_H2_DLE:     phase_d = dlm_pkg::PH_H2_SOH;
        dlm_pkg::PH_H2_SOH: begin
          phase_d = dlm_pkg::PH_H2_SKIP;
          count_d = '0;
        end
        dlm_pkg::PH_H2_SKIP: begin
          if (skip_done) begin
            count_d = '0;
            phase_d = dlm_pkg::PH_H2_ETX_DLE;
          end else begin
            count_d = count_inc;
          end
        end
        dlm_pkg::PH_H2_ETX_DLE: phase_d = dlm_pkg::PH_H2_ETX;
        dlm_pkg::PH_H2_ETX: begin
          phase_d = dlm_pkg::PH_H2_CRC;
          count_d = '0;
        end
        dlm_pkg::PH_H2_CRC: begin
          if (crc_done) begin
            count_d = '0;
            phase_d = dlm_pkg::PH_H2_EOT;
          end else begin
            count_d = count_inc;
          end
        end
        dlm_pkg::PH_H2_EOT: phase_d = dlm_pkg::PH_D_ENQ;
        dlm_pkg::PH_D_ENQ: begin
          phase_d  = dlm_pkg::PH_D_STX_DLE;
          toggle_d = 1'b1;  // first ack is '0'
        end
        dlm_pkg::PH_D_STX_DLE:  phase_d = dlm_pkg::PH_D_STX;
        dlm_pkg::PH_D_STX: begin
          phase_d  = dlm_pkg::PH_D_DATA;
          escape_d = 1'b0;
        end
        dlm_pkg::PH_D_DATA: begin
          if (escape_q) begin
            escape_d = 1'b0;
            if (rx_byte_i == dlm_pkg::CharEtb) begin
              phase_d = dlm_pkg::PH_D_CRC_ETB;
              count_d = '0;
            end else if (rx_byte_i == dlm_pkg::CharEtx) begin
              phase_d = dlm_pkg::PH_D_CRC_ETX;
              count_d = '0;
            end
          end else if (rx_byte_i == dlm_pkg::CharDle) begin
            escape_d = 1'b1;
          end
        end
        dlm_pkg::PH_D_CRC_ETB,
        dlm_pkg::PH_D_CRC_ETX: begin
          if (crc_done) begin
            count_d  = '0;
            toggle_d = ~toggle_q;
            phase_d  = (phase_q == dlm_pkg::PH_D_CRC_ETB) ? dlm_pkg::PH_D_STX_DLE
                                                           : dlm_pkg::PH_D_EOT;
          end else begin
            count_d = count_inc;
          end
        end
        default: phase_d = dlm_pkg::PH_IDLE;  // end of transfer
      endcase
      if (bad || phase_q == dlm_pkg::PH_D_EOT) begin
        phase_d  = dlm_pkg::PH_IDLE;
        count_d  = '0;
        toggle_d = 1'b0;
        escape_d = 1'b0;
      end
    end
  end

  // Burst to queue
  always_comb begin
    push_o.valid        = 1'b0;
    push_o.burst.cmd    = dlm_pkg::CMD_SINGLE;
    push_o.burst.kind   = dlm_pkg::KIND_TX;
    push_o.burst.data   = '0;
    push_o.burst.status = dlm_pkg::ST_COMPLETE;
    if (accept && op_i == dlm_pkg::OP_START) begin
      push_o.valid      = 1'b1;
      push_o.burst.data = dlm_pkg::CharEnq;
    end else if (accept && active && op_i == dlm_pkg::OP_TIMEOUT) begin
      push_o.valid        = 1'b1;
      push_o.burst.kind   = dlm_pkg::KIND_END;
      push_o.burst.status = dlm_pkg::ST_TIMEOUT;
    end else if (is_byte) begin
      if (bad) begin
        push_o.valid        = 1'b1;
        push_o.burst.kind   = dlm_pkg::KIND_END;
        push_o.burst.status = dlm_pkg::ST_UNEXPECTED;
      end else begin
        unique case (phase_q)
          dlm_pkg::PH_H1_ZERO: begin
            push_o.valid     = 1'b1;
            push_o.burst.cmd = dlm_pkg::CMD_ID;
          end
          dlm_pkg::PH_H1_ACK_ONE: begin
            push_o.valid      = 1'b1;
            push_o.burst.data = dlm_pkg::CharEot;
          end
          dlm_pkg::PH_H2_ENQ,
          dlm_pkg::PH_D_ENQ: begin
            push_o.valid      = 1'b1;
            push_o.burst.cmd  = dlm_pkg::CMD_ACK;
            push_o.burst.data = dlm_pkg::CharZero;
          end
          dlm_pkg::PH_H2_CRC: begin
            push_o.valid      = crc_done;
            push_o.burst.cmd  = dlm_pkg::CMD_ACK;
            push_o.burst.data = dlm_pkg::CharOne;
          end
          dlm_pkg::PH_D_DATA: begin
            push_o.valid = escape_q ? !(rx_byte_i == dlm_pkg::CharEtb ||
                                        rx_byte_i == dlm_pkg::CharEtx)
                                    : (rx_byte_i != dlm_pkg::CharDle);
            push_o.burst.kind = dlm_pkg::KIND_DATA;
            push_o.burst.data = rx_byte_i;
          end
          dlm_pkg::PH_D_CRC_ETB,
          dlm_pkg::PH_D_CRC_ETX: begin
            push_o.valid      = crc_done;
            push_o.burst.cmd  = dlm_pkg::CMD_ACK;
            push_o.burst.data = toggle_q ? dlm_pkg::CharOne : dlm_pkg::CharZero;
          end
          dlm_pkg::PH_D_EOT: begin
            push_o.valid        = 1'b1;
            push_o.burst.kind   = dlm_pkg::KIND_END;
            push_o.burst.status = (rx_byte_i == dlm_pkg::CharEot) ?
                                  dlm_pkg::ST_COMPLETE : dlm_pkg::ST_UNEXPECTED;
          end
          default: push_o.valid = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dlm_pkg::PH_IDLE;
      count_q  <= '0;
      toggle_q <= 1'b0;
      escape_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      toggle_q <= toggle_d;
      escape_q <= escape_d;
    end
  end

endmodule

`default_nettype wire

[rtl/dlm_queue.sv]
// ---------------------------------------------------------------------------
// dlm_queue
// Small FIFO of pending bursts between the session logic and the emitter.
// ---------------------------------------------------------------------------
`default_nettype none

`include "dex_ucs_link_master_top_assert.svh"

module dlm_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dlm_pkg::push_t   push_i,
  input  wire logic             pop_i,
  output dlm_pkg::burst_t       head_o,
  output logic                  head_valid_o,
  output logic                  full_o
);

  dlm_pkg::burst_t                mem_q [dlm_pkg::QueueDepth];
  logic [dlm_pkg::QueuePtrW-1:0]  wr_ptr_q;
  logic [dlm_pkg::QueuePtrW-1:0]  rd_ptr_q;
  logic [dlm_pkg::QueuePtrW:0]    count_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign head_valid_o = (count_q != '0);
  assign full_o       = (count_q == (dlm_pkg::QueuePtrW+1)'(dlm_pkg::QueueDepth));

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.burst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + (dlm_pkg::QueuePtrW)'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + (dlm_pkg::QueuePtrW)'(1);
      end
      case ({push_i.valid, pop_i})
        2'b10:   count_q <= count_q + (dlm_pkg::QueuePtrW+1)'(1);
        2'b01:   count_q <= count_q - (dlm_pkg::QueuePtrW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `DLM_ASSERT(a_no_overflow, (push_i.valid |-> !full_o))
  `DLM_ASSERT(a_no_underflow, (pop_i |-> head_valid_o))

endmodule

`default_nettype wire

[rtl/dlm_back.sv]
// ---------------------------------------------------------------------------
// dlm_back
// Burst emitter: expands queued bursts into result items, runs the ID CRC.
// ---------------------------------------------------------------------------
`default_nettype none

`include "dex_ucs_link_master_top_assert.svh"

module dlm_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dlm_pkg::burst_t  head_i,
  input  wire logic             head_valid_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [1:0]            kind_o,
  output logic [7:0]            out_byte_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);

  logic [4:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic [1:0]  status_q;
  logic        last_q;

  logic        emit;
  logic [1:0]  el_kind;
  logic [7:0]  el_byte;
  logic [1:0]  el_status;
  logic        el_last;
  logic        el_crc;

  assign emit  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = emit && el_last;

  // Current element of the burst at the head
  always_comb begin
    el_kind   = dlm_pkg::KIND_TX;
    el_byte   = head_i.data;
    el_status = dlm_pkg::ST_COMPLETE;
    el_last   = 1'b1;
    el_crc    = 1'b0;
    unique case (head_i.cmd)
      dlm_pkg::CMD_SINGLE: begin
        el_kind   = head_i.kind;
        el_status = head_i.status;
      end
      dlm_pkg::CMD_ACK: begin
        el_last = (idx_q != '0);
        if (idx_q == '0) begin
          el_byte = dlm_pkg::CharDle;
        end
      end
      dlm_pkg::CMD_ID: begin
        el_last = (idx_q == dlm_pkg::IdCrcHi);
        if (idx_q == dlm_pkg::IdDle1 || idx_q == dlm_pkg::IdDle2) begin
          el_byte = dlm_pkg::CharDle;
        end else if (idx_q == dlm_pkg::IdSoh) begin
          el_byte = dlm_pkg::CharSoh;
        end else if (idx_q == dlm_pkg::IdEtx) begin
          el_byte = dlm_pkg::CharEtx;
          el_crc  = 1'b1;
        end else if (idx_q == dlm_pkg::IdCrcLo) begin
          el_byte = crc_q[7:0];
        end else if (idx_q == dlm_pkg::IdCrcHi) begin
          el_byte = crc_q[15:8];
        end else begin
          el_byte = dlm_pkg::id_char(idx_q - dlm_pkg::IdTextLo);
          el_crc  = 1'b1;
        end
      end
      default: el_last = 1'b1;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    crc_d = crc_q;
    if (emit) begin
      idx_d = el_last ? 5'd0 : idx_q + 5'd1;
      if (head_i.cmd == dlm_pkg::CMD_ID) begin
        if (idx_q == dlm_pkg::IdDle1) begin
          crc_d = '0;
        end else if (el_crc) begin
          crc_d = dlm_pkg::crc_feed(crc_q, el_byte);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      crc_q <= crc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q   <= el_kind;
      byte_q   <= el_byte;
      status_q <= el_status;
      last_q   <= el_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign out_byte_o  = byte_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  `DLM_ASSERT(a_idx_range, (idx_q <= dlm_pkg::IdCrcHi))
  `DLM_ASSERT(a_burst_keeps_head, ((idx_q != '0) |-> head_valid_i))

endmodule

`default_nettype wire

[rtl/dex_ucs_link_master_top.sv]
// ---------------------------------------------------------------------------
// dex_ucs_link_master_top
// Master side of a DEX/UCS audit link, one received event per item.
// ---------------------------------------------------------------------------
//  channel  dir  handshake                 payload
//  in       in   in_valid_i / in_stall_o   op_i, rx_byte_i
//  out      out  out_valid_o / out_stall_i kind_o, out_byte_o, status_o, last_o
//
//  An input item is taken every cycle while the burst queue has room; its
//  first result is written to the queue and then loaded into the output register.
//  Results leave at one per cycle while out_stall_i is low; the ID burst has
//  23 results, every other burst one or two, and items without results push
//  no burst.
//  rst_ni clears the session state, the queue and the output valid at once.
//  out_stall_i holds the output register; the four-entry queue then fills
//  and raises in_stall_o.
// ---------------------------------------------------------------------------
`default_nettype none

module dex_ucs_link_master_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      status_o,
  output logic            last_o
);

  dlm_pkg::push_t  push;
  dlm_pkg::burst_t head;
  logic            head_valid;
  logic            queue_full;
  logic            pop;

  dlm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .rx_byte_i    (rx_byte_i),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  dlm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .full_o       (queue_full)
  );

  dlm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire
